// File: rtl/core/ptts_pkg.sv
package ptts_pkg;

	localparam int NUM_CH    = 10;
	localparam int NUM_REGS  = 6;
	localparam int REG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// Channel positions in the pending mask
	localparam int CH_NOISE      = 0;
	localparam int CH_SEND       = 1;
	localparam int CH_TEMP       = 2;
	localparam int CH_LED        = 3;
	localparam int CH_BUZZER     = 4;
	localparam int CH_CLOCK      = 5;
	localparam int CH_DUSTWD     = 6;
	localparam int CH_NOISEWD    = 7;
	localparam int CH_ALARMWRITE = 8;
	localparam int CH_INDICATOR  = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAST        = 3'd0,
		REG_SEND        = 3'd1,
		REG_TEMP        = 3'd2,
		REG_TIMEOUT     = 3'd3,
		REG_ALARM_WRITE = 3'd4,
		REG_INDICATOR   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		KIND_TICK    = 1'b0,
		KIND_COLLECT = 1'b1
	} kind_t;

	typedef logic [REG_W-1:0] reg_word_t;
	typedef reg_word_t [NUM_REGS-1:0] reg_file_t;

	// Per-transaction control from the core to every channel
	typedef struct packed {
		logic tick;
		logic collect;
	} ctrl_t;

	localparam reg_word_t REG_DEFAULT [NUM_REGS] = '{
		16'd500, 16'd3000, 16'd1000, 16'd6000, 16'd10000, 16'd20
	};

	// Register that supplies each channel's period
	localparam reg_idx_t CHAN_REG [NUM_CH] = '{
		REG_FAST, REG_SEND, REG_TEMP, REG_FAST, REG_FAST,
		REG_FAST, REG_TIMEOUT, REG_TIMEOUT, REG_ALARM_WRITE, REG_INDICATOR
	};

endpackage

// File: rtl/core/ptts_cfg.sv
module ptts_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ptts_pkg::REG_W-1:0]        cfg_data,
	output ptts_pkg::reg_file_t               regs
);

	ptts_pkg::reg_file_t regs_q;

	// Always able to take a write
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Store period registers; drop writes beyond the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptts_pkg::NUM_REGS; i++) begin
				regs_q[i] <= ptts_pkg::REG_DEFAULT[i];
			end
		end else if (cfg_valid) begin
			case (ptts_pkg::reg_idx_t'(cfg_index))
				ptts_pkg::REG_FAST:        regs_q[ptts_pkg::REG_FAST]        <= cfg_data;
				ptts_pkg::REG_SEND:        regs_q[ptts_pkg::REG_SEND]        <= cfg_data;
				ptts_pkg::REG_TEMP:        regs_q[ptts_pkg::REG_TEMP]        <= cfg_data;
				ptts_pkg::REG_TIMEOUT:     regs_q[ptts_pkg::REG_TIMEOUT]     <= cfg_data;
				ptts_pkg::REG_ALARM_WRITE: regs_q[ptts_pkg::REG_ALARM_WRITE] <= cfg_data;
				ptts_pkg::REG_INDICATOR:   regs_q[ptts_pkg::REG_INDICATOR]   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/ptts_chan.sv
module ptts_chan #(
	parameter int COUNT_WIDTH  = 16,
	parameter int RESET_PERIOD = 500
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ptts_pkg::ctrl_t            ctrl,
	input  logic [ptts_pkg::REG_W-1:0] period,
	input  logic                       wd_reload,
	input  logic                       fire_flag,
	output logic                       pending,
	output logic                       pending_next
);

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_d;
	logic [COUNT_WIDTH-1:0] reload_val;
	logic [COUNT_WIDTH-1:0] after;
	logic                   pend_q;
	logic                   pend_d;

	assign reload_val = COUNT_WIDTH'(period);

	// Count down; a watchdog reloads on valid data; reload and flag on zero
	always_comb begin
		count_d = count_q;
		pend_d  = pend_q;
		after   = count_q - COUNT_WIDTH'(1);
		if (wd_reload) begin
			after = reload_val;
		end
		if (ctrl.tick && (count_q != '0)) begin
			if (after == '0) begin
				count_d = reload_val;
				pend_d  = fire_flag;
			end else begin
				count_d = after;
			end
		end else if (ctrl.collect) begin
			pend_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_WIDTH'(RESET_PERIOD);
			pend_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			pend_q  <= pend_d;
		end
	end

	assign pending      = pend_q;
	assign pending_next = pend_d;

	// Counts move only on a tick
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.tick |=> $stable(count_q))
		else $error("channel count moved without a tick");

	// A stopped channel stays stopped
	a_zero_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |=> (count_q == '0))
		else $error("stopped channel restarted");

endmodule

// File: rtl/core/periodic_task_tick_scheduler_core.sv
// Channel   Handshake              Payload
// in        in_valid / in_stall    kind, dust_data_valid, noise_data_valid,
//                                  noise_high, dust_high, alarm_muted
// out       out_valid / out_stall  pending_mask
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle while out_stall is low; each passes from the input
// register to the result register, which raises out_valid.
// All ten channel counters update in parallel as the result register loads.
// Reset loads every counter with its default period and clears all flags.
// A stalled result holds the result register; the input register still takes
// a transaction while empty, and in_stall rises once it holds one.
module periodic_task_tick_scheduler_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    kind,
	input  logic                                    dust_data_valid,
	input  logic                                    noise_data_valid,
	input  logic                                    noise_high,
	input  logic                                    dust_high,
	input  logic                                    alarm_muted,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [ptts_pkg::NUM_CH-1:0]             pending_mask,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [ptts_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ptts_pkg::REG_W-1:0]              cfg_data
);

	logic                            valid_s1;
	logic                            kind_s1;
	logic                            dust_ok_s1;
	logic                            noise_ok_s1;
	logic                            led_flag_s1;
	logic                            buzzer_flag_s1;
	logic                            out_valid_q;
	logic [ptts_pkg::NUM_CH-1:0]     mask_q;
	logic                            out_free;
	logic                            proc;
	ptts_pkg::ctrl_t                 ctrl;
	ptts_pkg::reg_file_t             regs;
	logic [ptts_pkg::NUM_CH-1:0]     pend_vec;
	logic [ptts_pkg::NUM_CH-1:0]     pend_next_vec;
	logic [ptts_pkg::NUM_CH-1:0]     wd_vec;
	logic [ptts_pkg::NUM_CH-1:0]     flag_vec;

	ptts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// Handshake: the input register advances whenever its content can move on
	assign out_free = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	assign ctrl.tick    = proc && (kind_s1 == ptts_pkg::KIND_TICK);
	assign ctrl.collect = proc && (kind_s1 == ptts_pkg::KIND_COLLECT);

	// Hold the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1        <= kind;
			dust_ok_s1     <= dust_data_valid;
			noise_ok_s1    <= noise_data_valid;
			led_flag_s1    <= (noise_high || dust_high) && !alarm_muted;
			buzzer_flag_s1 <= noise_high && dust_high && !alarm_muted;
		end
	end

	// Channel bank
	generate
		for (genvar ch = 0; ch < ptts_pkg::NUM_CH; ch++) begin : g_chan
			if (ch == ptts_pkg::CH_DUSTWD) begin : g_wd
				assign wd_vec[ch] = dust_ok_s1;
			end else if (ch == ptts_pkg::CH_NOISEWD) begin : g_wd
				assign wd_vec[ch] = noise_ok_s1;
			end else begin : g_wd
				assign wd_vec[ch] = 1'b0;
			end

			if (ch == ptts_pkg::CH_LED) begin : g_flag
				assign flag_vec[ch] = led_flag_s1;
			end else if (ch == ptts_pkg::CH_BUZZER) begin : g_flag
				assign flag_vec[ch] = buzzer_flag_s1;
			end else begin : g_flag
				assign flag_vec[ch] = 1'b1;
			end

			ptts_chan #(
				.COUNT_WIDTH  (COUNT_WIDTH),
				.RESET_PERIOD (int'(ptts_pkg::REG_DEFAULT[ptts_pkg::CHAN_REG[ch]]))
			) u_chan (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.period       (regs[ptts_pkg::CHAN_REG[ch]]),
				.wd_reload    (wd_vec[ch]),
				.fire_flag    (flag_vec[ch]),
				.pending      (pend_vec[ch]),
				.pending_next (pend_next_vec[ch])
			);
		end
	endgenerate

	// Result register: flags after a tick, flags before clearing on a collect
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			mask_q <= ctrl.collect ? pend_vec : pend_next_vec;
		end
	end

	assign out_valid    = out_valid_q;
	assign pending_mask = mask_q;

	// Back-pressure only arises from a held input transaction
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// A processed transaction always lands in the result register
	a_proc_result: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> out_valid_q)
		else $error("processed transaction produced no result");

	// A collect leaves every pending flag clear
	a_collect_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.collect |=> (pend_vec == '0))
		else $error("pending flags survived a collect");

endmodule
